@@ design/spq_pkg.sv @@
// Shared types, constants and codes for the sorted priority queue.
package spq_pkg;

	localparam int DEPTH  = 16;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CAP_W  = 5;
	localparam int DATA_W = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// Opcodes
	localparam logic [1:0] OP_ENQ  = 2'd0;
	localparam logic [1:0] OP_DEQ  = 2'd1;
	localparam logic [1:0] OP_PEEK = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;

	localparam logic signed [DATA_W-1:0] EMPTY_DATA = -32'sd1;

	typedef struct packed {
		logic [1:0]               opcode;
		logic signed [DATA_W-1:0] item_data;
		logic signed [DATA_W-1:0] item_priority;
	} in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_data;
		logic [1:0]               status;
	} out_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic signed [DATA_W-1:0] prio;
	} entry_t;

	// Broadcast to every cell for one operation
	typedef struct packed {
		logic                     enq;
		logic                     deq;
		logic signed [DATA_W-1:0] prio;
	} cell_ctl_t;

endpackage

@@ design/spq_cell.sv @@
// One slot of the sorted chain: holds an entry and shifts left or right with its neighbors.
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  logic               occupied,
	input  logic               left_ins,
	input  spq_pkg::entry_t    new_entry,
	input  spq_pkg::entry_t    left_entry,
	input  spq_pkg::entry_t    right_entry,
	output spq_pkg::entry_t    entry,
	output logic               ins
);

	spq_pkg::entry_t entry_q;

	// New item lands at or before this slot
	assign ins = !occupied || (entry_q.prio > ctl.prio);

	// Slot update: insert, shift right on enqueue, shift left on dequeue
	always_ff @(posedge clk) begin
		if (ctl.enq && ins) begin
			if (left_ins) begin
				entry_q <= left_entry;
			end else begin
				entry_q <= new_entry;
			end
		end else if (ctl.deq) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;

endmodule

@@ design/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: cell chain, count, capacity and output register.
//
// Sorted priority queue with up to DEPTH entries kept in a chain of cells.
// Input channel (in_valid/in_ready/in_data) carries one operation per beat:
// enqueue, dequeue or peek. Output channel (out_valid/out_ready/out_data)
// returns exactly one beat per operation with result_data and status.
// Entries are ordered by ascending signed priority; equal priorities keep
// arrival order. Every cell compares its priority with the incoming one in
// parallel and shifts with its neighbor, so the whole chain updates on the
// clock edge that accepts an operation. The result is registered, and out_valid
// rises in the cycle after the input beat. One operation can be accepted every
// cycle while the receiver keeps up; the one-deep output register sets that rate.
// When the receiver stalls, the result waits in the output register and
// in_ready drops until it is taken.
// cfg_we/cfg_wdata write capacity_limit, which clamps to DEPTH; write it
// only while the queue is idle.
// Reset (arst_n low) empties the queue and sets capacity_limit to 16.
// Cell contents are not reset; slots past the entry count are never read.
//
module sorted_priority_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  spq_pkg::in_t                in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output spq_pkg::out_t               out_data,
	input  logic                        cfg_we,
	input  logic [spq_pkg::CAP_W-1:0]   cfg_wdata
);

	logic [spq_pkg::CNT_W-1:0] cnt_q;
	logic [spq_pkg::CAP_W-1:0] cap_q;
	logic                      out_valid_q;
	spq_pkg::out_t             out_q;

	logic                      acc;
	logic                      full;
	logic                      is_empty;
	logic [spq_pkg::CNT_W-1:0] cap_eff;
	spq_pkg::cell_ctl_t        ctl;
	spq_pkg::entry_t           new_entry;
	spq_pkg::out_t             res;

	spq_pkg::entry_t           cell_entry [spq_pkg::DEPTH];
	logic                      cell_ins   [spq_pkg::DEPTH];

	// Handshake
	assign in_ready  = !out_valid_q || out_ready;
	assign acc       = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Effective capacity and occupancy
	always_comb begin
		if ({{(spq_pkg::CNT_W){1'b0}}, cap_q} > (spq_pkg::CNT_W + spq_pkg::CAP_W)'(spq_pkg::DEPTH))
		begin
			cap_eff = spq_pkg::CNT_W'(spq_pkg::DEPTH);
		end else begin
			cap_eff = spq_pkg::CNT_W'(cap_q);
		end
	end
	assign full     = cnt_q >= cap_eff;
	assign is_empty = cnt_q == '0;

	// Broadcast control to the chain
	assign ctl.enq  = acc && (in_data.opcode == spq_pkg::OP_ENQ) && !full;
	assign ctl.deq  = acc && (in_data.opcode == spq_pkg::OP_DEQ) && !is_empty;
	assign ctl.prio = in_data.item_priority;
	assign new_entry.data = in_data.item_data;
	assign new_entry.prio = in_data.item_priority;

	// Cell chain
	for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
		logic            occ;
		logic            l_ins;
		spq_pkg::entry_t l_entry;
		spq_pkg::entry_t r_entry;

		assign occ = spq_pkg::CNT_W'(i) < cnt_q;

		if (i == 0) begin : g_head
			assign l_ins   = 1'b0;
			assign l_entry = new_entry;
		end else begin : g_body
			assign l_ins   = cell_ins[i-1];
			assign l_entry = cell_entry[i-1];
		end

		if (i == spq_pkg::DEPTH - 1) begin : g_tail
			assign r_entry = cell_entry[i];
		end else begin : g_mid
			assign r_entry = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (occ),
			.left_ins   (l_ins),
			.new_entry  (new_entry),
			.left_entry (l_entry),
			.right_entry(r_entry),
			.entry      (cell_entry[i]),
			.ins        (cell_ins[i])
		);
	end

	// Result decode
	always_comb begin
		res.result_data = '0;
		res.status      = spq_pkg::ST_OK;
		unique case (in_data.opcode)
			spq_pkg::OP_ENQ: begin
				if (full) begin
					res.status = spq_pkg::ST_OVERFLOW;
				end
			end
			spq_pkg::OP_DEQ, spq_pkg::OP_PEEK: begin
				if (is_empty) begin
					res.result_data = spq_pkg::EMPTY_DATA;
					res.status      = spq_pkg::ST_EMPTY;
				end else begin
					res.result_data = cell_entry[0].data;
				end
			end
			default: begin
				res.result_data = '0;
				res.status      = spq_pkg::ST_OK;
			end
		endcase
	end

	// Count, capacity and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			cap_q       <= spq_pkg::CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (ctl.enq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (ctl.deq) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (acc) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (acc) begin
			out_q <= res;
		end
	end

	// Count never passes the number of cells
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= spq_pkg::CNT_W'(spq_pkg::DEPTH))
		else $error("entry count above depth");

	// Empty status always carries the empty marker
	a_empty_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.status == spq_pkg::ST_EMPTY) |->
		out_q.result_data == spq_pkg::EMPTY_DATA)
		else $error("empty result without -1 data");

	// A successful dequeue drops the count by one
	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.deq |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("dequeue did not decrement count");

	// An accepted enqueue with room raises the count by one
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (in_data.opcode == spq_pkg::OP_ENQ) && !full |=>
		cnt_q == $past(cnt_q) + 1'b1)
		else $error("accepted enqueue did not increment count");

endmodule

@@ tb/sv/tb_sorted_priority_queue.sv @@
// Self-checking testbench for the sorted priority queue: directed rows, then random phases.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;

	localparam logic [1:0] OP_NOP = 2'd3;
	localparam logic signed [spq_pkg::DATA_W-1:0] PRIO_MIN = 32'sh8000_0000;
	localparam logic signed [spq_pkg::DATA_W-1:0] PRIO_MAX = 32'sh7fff_ffff;
	localparam int QUIET_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 190;

	// One row of the directed part: either a capacity write or one operation
	typedef struct packed {
		bit                        is_cfg;
		logic [spq_pkg::CAP_W-1:0] cap;
		spq_pkg::in_t              op;
		bit                        fixed;
		spq_pkg::out_t             want;
	} dir_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	spq_pkg::in_t              in_data = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	spq_pkg::out_t             out_data;
	logic                      cfg_we = 1'b0;
	logic [spq_pkg::CAP_W-1:0] cfg_wdata = '0;

	// Sideband that travels with each input beat: a hand-typed result, if any
	logic          fixed_check = 1'b0;
	spq_pkg::out_t fixed_result = '0;

	// Shadow of the queue contents and capacity
	spq_pkg::entry_t           held_entries[$];
	logic [spq_pkg::CAP_W-1:0] cap_limit;

	spq_pkg::out_t pending_results[$];
	dir_row_t      directed_rows[$];
	int            mismatch_count = 0;
	int            burst_left = 0;
	int            quiet_cycles = 0;
	int            rx_left = 0;
	int            rx_mode = 0;
	spq_pkg::out_t predicted;
	spq_pkg::out_t oldest;

	sorted_priority_queue uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// Apply one operation to the shadow queue and return the result it produces
	function automatic spq_pkg::out_t apply_queue_op(input spq_pkg::in_t op);
		spq_pkg::out_t   r;
		spq_pkg::entry_t e;
		int              pos;
		int              cap_eff;
		r.result_data = '0;
		r.status      = spq_pkg::ST_OK;
		cap_eff = (cap_limit > spq_pkg::DEPTH) ? spq_pkg::DEPTH : int'(cap_limit);
		case (op.opcode)
			spq_pkg::OP_ENQ: begin
				if (held_entries.size() >= cap_eff) begin
					r.status = spq_pkg::ST_OVERFLOW;
				end else begin
					// after every entry with lower or equal priority
					pos = 0;
					while (pos < held_entries.size() &&
					       held_entries[pos].prio <= op.item_priority)
						pos++;
					e.data = op.item_data;
					e.prio = op.item_priority;
					held_entries.insert(pos, e);
				end
			end
			spq_pkg::OP_DEQ, spq_pkg::OP_PEEK: begin
				if (held_entries.size() == 0) begin
					r.result_data = spq_pkg::EMPTY_DATA;
					r.status      = spq_pkg::ST_EMPTY;
				end else begin
					r.result_data = held_entries[0].data;
					if (op.opcode == spq_pkg::OP_DEQ)
						void'(held_entries.pop_front());
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic void add_row(input bit is_cfg, input logic [spq_pkg::CAP_W-1:0] cap,
			input logic [1:0] opc, input logic signed [spq_pkg::DATA_W-1:0] d,
			input logic signed [spq_pkg::DATA_W-1:0] p, input bit fixed,
			input logic signed [spq_pkg::DATA_W-1:0] want_d, input logic [1:0] want_st);
		dir_row_t row;
		row.is_cfg             = is_cfg;
		row.cap                = cap;
		row.op.opcode          = opc;
		row.op.item_data       = d;
		row.op.item_priority   = p;
		row.fixed              = fixed;
		row.want.result_data   = want_d;
		row.want.status        = want_st;
		directed_rows.push_back(row);
	endfunction

	// Random operation; fill mode leans toward enqueue, drain mode toward dequeue
	function automatic spq_pkg::in_t make_random_op(input bit fill);
		spq_pkg::in_t op;
		int           r;
		r = $urandom_range(0, 99);
		if (r < 4)
			op.opcode = OP_NOP;
		else if (r < 19)
			op.opcode = spq_pkg::OP_PEEK;
		else if (r < (fill ? 75 : 43))
			op.opcode = spq_pkg::OP_ENQ;
		else
			op.opcode = spq_pkg::OP_DEQ;
		op.item_data = $urandom;
		case ($urandom_range(0, 7))
			0, 1, 2, 3: op.item_priority = int'($urandom_range(0, 8)) - 4;
			6: begin
				case ($urandom_range(0, 3))
					0: op.item_priority = PRIO_MIN;
					1: op.item_priority = PRIO_MAX;
					2: op.item_priority = '0;
					default: op.item_priority = -32'sd1;
				endcase
			end
			default: op.item_priority = $urandom;
		endcase
		return op;
	endfunction

	// Present one beat, idling between bursts, and hold it until accepted
	task automatic send_op(input spq_pkg::in_t op, input bit fixed, input spq_pkg::out_t want);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 30);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid     <= 1'b1;
		in_data      <= op;
		fixed_check  <= fixed;
		fixed_result <= want;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		burst_left--;
	endtask

	// Capacity write once the queue has drained its results
	task automatic write_capacity(input logic [spq_pkg::CAP_W-1:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cap_limit  = value;
		burst_left = 0;
	endtask

	// Receiver: ready pattern switches among four modes whenever its countdown runs out
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_left <= $urandom_range(16, 80);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 1) == 0);
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= (rx_left[2:0] != 3'd0);
		endcase
	end

	// Predict on each input beat, check each output beat against the oldest result
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predicted = apply_queue_op(in_data);
				pending_results.push_back(fixed_check ? fixed_result : predicted);
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result beat: data %0d status %0d",
						         out_data.result_data, out_data.status);
				end else begin
					oldest = pending_results.pop_front();
					if (out_data.result_data !== oldest.result_data ||
					    out_data.status !== oldest.status) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: data exp %0d got %0d, status exp %0d got %0d",
							         oldest.result_data, out_data.result_data,
							         oldest.status, out_data.status);
					end
				end
			end
		end
	end

	// Watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		logic [spq_pkg::CAP_W-1:0] phase_caps[10];
		int           fill_left;
		bit           fill;
		spq_pkg::in_t op;

		phase_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd2, 5'd16, 5'd15, 5'd8};
		cap_limit = spq_pkg::CAP_RESET;

		// Directed rows: empty queue, extremes, ties, head insert, overflow cases
		add_row(0, 0, spq_pkg::OP_PEEK, 0, 0, 1, spq_pkg::EMPTY_DATA, spq_pkg::ST_EMPTY);
		add_row(0, 0, spq_pkg::OP_DEQ, -1, -1, 1, spq_pkg::EMPTY_DATA, spq_pkg::ST_EMPTY);
		add_row(0, 0, OP_NOP, 0, 0, 1, 0, spq_pkg::ST_OK);
		add_row(0, 0, spq_pkg::OP_ENQ, PRIO_MAX, PRIO_MAX, 1, 0, spq_pkg::ST_OK);
		add_row(0, 0, spq_pkg::OP_ENQ, PRIO_MIN, PRIO_MIN, 1, 0, spq_pkg::ST_OK);
		add_row(0, 0, spq_pkg::OP_ENQ, 1, 0, 1, 0, spq_pkg::ST_OK);
		add_row(0, 0, spq_pkg::OP_ENQ, 2, 0, 1, 0, spq_pkg::ST_OK);
		add_row(0, 0, spq_pkg::OP_ENQ, 3, -1, 1, 0, spq_pkg::ST_OK);
		add_row(0, 0, spq_pkg::OP_PEEK, PRIO_MAX, PRIO_MAX, 0, 0, spq_pkg::ST_OK);
		add_row(0, 0, spq_pkg::OP_DEQ, 0, 0, 0, 0, spq_pkg::ST_OK);
		add_row(0, 0, spq_pkg::OP_DEQ, 0, 0, 0, 0, spq_pkg::ST_OK);
		add_row(0, 0, spq_pkg::OP_DEQ, 0, 0, 0, 0, spq_pkg::ST_OK);
		add_row(0, 0, spq_pkg::OP_DEQ, 0, 0, 0, 0, spq_pkg::ST_OK);
		add_row(0, 0, spq_pkg::OP_ENQ, 10, 5, 1, 0, spq_pkg::ST_OK);
		add_row(0, 0, spq_pkg::OP_ENQ, 11, -5, 1, 0, spq_pkg::ST_OK);
		add_row(0, 0, spq_pkg::OP_PEEK, 0, 0, 0, 0, spq_pkg::ST_OK);
		// capacity below the current count
		add_row(1, 5'd2, OP_NOP, 0, 0, 0, 0, spq_pkg::ST_OK);
		add_row(0, 0, spq_pkg::OP_ENQ, 12, 0, 1, 0, spq_pkg::ST_OVERFLOW);
		add_row(0, 0, spq_pkg::OP_DEQ, 0, 0, 0, 0, spq_pkg::ST_OK);
		add_row(0, 0, spq_pkg::OP_ENQ, 13, 0, 1, 0, spq_pkg::ST_OVERFLOW);
		add_row(0, 0, spq_pkg::OP_DEQ, 0, 0, 0, 0, spq_pkg::ST_OK);
		add_row(0, 0, spq_pkg::OP_ENQ, 14, PRIO_MIN, 1, 0, spq_pkg::ST_OK);
		add_row(1, 5'd0, OP_NOP, 0, 0, 0, 0, spq_pkg::ST_OK);
		add_row(0, 0, spq_pkg::OP_ENQ, 15, 1, 1, 0, spq_pkg::ST_OVERFLOW);
		// capacity above DEPTH clamps
		add_row(1, 5'd31, OP_NOP, 0, 0, 0, 0, spq_pkg::ST_OK);
		add_row(0, 0, spq_pkg::OP_ENQ, 16, PRIO_MAX, 1, 0, spq_pkg::ST_OK);
		add_row(0, 0, OP_NOP, -1, PRIO_MIN, 1, 0, spq_pkg::ST_OK);
		add_row(0, 0, spq_pkg::OP_DEQ, 0, 0, 0, 0, spq_pkg::ST_OK);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg)
				write_capacity(directed_rows[i].cap);
			else
				send_op(directed_rows[i].op, directed_rows[i].fixed, directed_rows[i].want);
		end

		// Random phases, one capacity setting each
		foreach (phase_caps[ph]) begin
			write_capacity(phase_caps[ph]);
			fill = 1'b1;
			fill_left = $urandom_range(8, 40);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (fill_left == 0) begin
					fill = ~fill;
					fill_left = $urandom_range(8, 40);
				end
				fill_left--;
				op = make_random_op(fill);
				send_op(op, 1'b0, '0);
			end
		end

		// Drain and settle
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
